// ===== hdl/wfd_pkg.sv =====
// wfd_pkg: shared types, constants and the CRC-8 byte update for the weather frame decoder.
// No dependencies.
package wfd_pkg;

	localparam logic [7:0] CRC_POLY     = 8'h31;
	localparam logic [7:0] CRC_TOP      = 8'h80;
	localparam logic [7:0] HDR_VALUE    = 8'hff;
	localparam logic [3:0] IDX_CAP      = 4'd12;
	localparam logic [3:0] IDX_LAST     = 4'd10;
	localparam logic [3:0] IDX_CRC_LO   = 4'd1;
	localparam logic [3:0] IDX_FLD_LO   = 4'd2;
	localparam logic [3:0] IDX_FLD_HI   = 4'd9;
	localparam int         NUM_FLD      = 8;
	localparam int         FLD_AW       = $clog2(NUM_FLD);
	localparam int         Q_DEPTH      = 2;
	localparam int         Q_AW         = $clog2(Q_DEPTH);
	localparam logic [12:0] TEMP_OFFSET = 13'd400;
	localparam logic [13:0] WIND_SCALE  = 14'd34;
	localparam logic [13:0] RAIN_SCALE  = 14'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_LEN = 2'd1;
	localparam logic [1:0] ST_BAD_HDR = 2'd2;
	localparam logic [1:0] ST_BAD_CRC = 2'd3;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic [1:0]            status;
		byte_t [NUM_FLD-1:0]   fld;
	} frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic byte_t crc8_byte(input byte_t crc, input byte_t b);
		byte_t c;
		byte_t d;
		logic  top;
		c = crc;
		d = b;
		for (int k = 0; k < 8; k++) begin
			top = |((c ^ d) & CRC_TOP);
			c   = {c[6:0], 1'b0};
			if (top) begin
				c = c ^ CRC_POLY;
			end
			d = {d[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ===== hdl/wfd_front.sv =====
// wfd_front: takes burst bytes, tracks index, header and CRC, captures field bytes,
// and pushes one frame record per burst. Depends on wfd_pkg.
module wfd_front
	import wfd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    accept,
	input  byte_t   data_byte,
	input  logic    last_byte,
	output logic    push,
	output frame_t  rec
);

	logic [3:0]        idx_q;
	byte_t             crc_q;
	logic              hdr_q;
	byte_t             fld_q [NUM_FLD];
	logic [FLD_AW-1:0] fld_off;
	logic              in_crc;
	logic              in_fld;

	assign in_crc  = (idx_q >= IDX_CRC_LO) && (idx_q <= IDX_FLD_HI);
	assign in_fld  = (idx_q >= IDX_FLD_LO) && (idx_q <= IDX_FLD_HI);
	assign fld_off = FLD_AW'(idx_q - IDX_FLD_LO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			crc_q <= '0;
			hdr_q <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				idx_q <= '0;
				crc_q <= '0;
				hdr_q <= 1'b0;
			end else begin
				idx_q <= (idx_q >= IDX_CAP) ? IDX_CAP : idx_q + 4'd1;
				if (idx_q == '0) begin
					hdr_q <= (data_byte == HDR_VALUE);
				end
				if (in_crc) begin
					crc_q <= crc8_byte(crc_q, data_byte);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_fld) begin
			fld_q[fld_off] <= data_byte;
		end
	end

	assign push = accept && last_byte;

	always_comb begin
		if (idx_q != IDX_LAST) begin
			rec.status = ST_BAD_LEN;
		end else if (!hdr_q) begin
			rec.status = ST_BAD_HDR;
		end else if (crc_q != data_byte) begin
			rec.status = ST_BAD_CRC;
		end else begin
			rec.status = ST_OK;
		end
		for (int i = 0; i < NUM_FLD; i++) begin
			rec.fld[i] = fld_q[i];
		end
	end

endmodule

// ===== hdl/wfd_fifo.sv =====
// wfd_fifo: short queue of frame records between front and back.
// Depends on wfd_pkg.
module wfd_fifo
	import wfd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  frame_t  wdata,
	input  logic    pop,
	output frame_t  rdata,
	output q_stat_t stat
);

	frame_t          mem [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_AW:0]   cnt_q;

	assign stat.full  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rdata      = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == Q_AW'(Q_DEPTH-1)) ? '0 : wr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == Q_AW'(Q_DEPTH-1)) ? '0 : rd_q + Q_AW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (Q_AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (Q_AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hdl/wfd_back.sv =====
// wfd_back: pops frame records, scales the fields to fixed point and holds the
// result in an output register. Depends on wfd_pkg.
module wfd_back
	import wfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  frame_t             rec,
	input  q_stat_t            qstat,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [12:0] temperature_tenths,
	output logic [7:0]         humidity_pct,
	output logic [13:0]        avg_wind_hundredths,
	output logic [13:0]        gust_wind_hundredths,
	output logic [13:0]        rain_tenths,
	output logic [3:0]         battery_bits,
	output logic [3:0]         wind_dir_code
);

	logic               vld_q;
	logic [1:0]         status_q;
	logic signed [12:0] temp_q;
	logic [7:0]         hum_q;
	logic [13:0]        avg_q;
	logic [13:0]        gust_q;
	logic [13:0]        rain_q;
	logic [3:0]         batt_q;
	logic [3:0]         dir_q;
	logic               ok;
	logic [11:0]        t_raw;
	logic [11:0]        r_raw;

	assign pop   = !qstat.empty && (!vld_q || !out_stall);
	assign ok    = (rec.status == ST_OK);
	assign t_raw = {rec.fld[0][3:0], rec.fld[1]};
	assign r_raw = {rec.fld[5][3:0], rec.fld[6]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (pop) begin
			vld_q <= 1'b1;
		end else if (!out_stall) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= rec.status;
			temp_q   <= ok ? $signed({1'b0, t_raw} - TEMP_OFFSET) : '0;
			hum_q    <= ok ? rec.fld[2] : '0;
			avg_q    <= ok ? {6'b0, rec.fld[3]} * WIND_SCALE : '0;
			gust_q   <= ok ? {6'b0, rec.fld[4]} * WIND_SCALE : '0;
			rain_q   <= ok ? {2'b0, r_raw} * RAIN_SCALE : '0;
			batt_q   <= ok ? rec.fld[7][7:4] : '0;
			dir_q    <= ok ? rec.fld[7][3:0] : '0;
		end
	end

	assign out_valid            = vld_q;
	assign status               = status_q;
	assign temperature_tenths   = temp_q;
	assign humidity_pct         = hum_q;
	assign avg_wind_hundredths  = avg_q;
	assign gust_wind_hundredths = gust_q;
	assign rain_tenths          = rain_q;
	assign battery_bits         = batt_q;
	assign wind_dir_code        = dir_q;

endmodule

// ===== hdl/weather_frame_decoder_top.sv =====
// weather_frame_decoder_top: burst byte decoder with CRC-8 check and fixed-point fields.
// Depends on wfd_pkg, wfd_front, wfd_fifo, wfd_back.
//
//   channel  handshake              payload
//   in       in_valid / in_stall    data_byte, last_byte
//   out      out_valid / out_stall  status, temperature_tenths, humidity_pct,
//                                   avg_wind_hundredths, gust_wind_hundredths,
//                                   rain_tenths, battery_bits, wind_dir_code
//
// One byte per cycle while in_stall is low; the CRC update is one byte-wide step per item.
// A burst's record is queued with its last byte and popped into the output register when the output is free.
// Two frame records queue between front and back; in_stall rises only when both are held.
// arst_n clears the byte count, CRC, header flag, queue and output valid.
module weather_frame_decoder_top
	import wfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [12:0] temperature_tenths,
	output logic [7:0]         humidity_pct,
	output logic [13:0]        avg_wind_hundredths,
	output logic [13:0]        gust_wind_hundredths,
	output logic [13:0]        rain_tenths,
	output logic [3:0]         battery_bits,
	output logic [3:0]         wind_dir_code
);

	logic    accept;
	logic    push;
	logic    pop;
	frame_t  rec_in;
	frame_t  rec_out;
	q_stat_t qstat;

	assign in_stall = qstat.full;
	assign accept   = in_valid && !in_stall;

	wfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.push      (push),
		.rec       (rec_in)
	);

	wfd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (rec_in),
		.pop    (pop),
		.rdata  (rec_out),
		.stat   (qstat)
	);

	wfd_back u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.rec                  (rec_out),
		.qstat                (qstat),
		.pop                  (pop),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.status               (status),
		.temperature_tenths   (temperature_tenths),
		.humidity_pct         (humidity_pct),
		.avg_wind_hundredths  (avg_wind_hundredths),
		.gust_wind_hundredths (gust_wind_hundredths),
		.rain_tenths          (rain_tenths),
		.battery_bits         (battery_bits),
		.wind_dir_code        (wind_dir_code)
	);

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// testbench: random and directed bursts into weather_frame_decoder_top, checks every frame report
// against an in-bench decoder model. Depends on wfd_pkg and the RTL under hdl/.
module testbench
	import wfd_pkg::*;
();

	localparam byte_t GEN_POLY    = 8'h31;
	localparam byte_t SYNC_BYTE   = 8'hff;
	localparam int    FRAME_LEN   = 11;
	localparam int    POS_CAP     = 12;
	localparam int    ITEM_TARGET = 1100;
	localparam int    BUF_LEN     = 24;
	localparam int    DRAIN_CYC   = 20;
	localparam int    CYCLE_LIMIT = 600000;
	localparam int    MAX_REPORTS = 10;

	typedef enum int {GOOD_FRAME, CRC_FLIP, HDR_BAD, LEN_BAD, NOISE} burst_kind_t;

	typedef struct packed {
		byte_t data;
		logic  last;
	} burst_byte_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [12:0] temp;
		logic [7:0]         hum;
		logic [13:0]        avg;
		logic [13:0]        gust;
		logic [13:0]        rain;
		logic [3:0]         batt;
		logic [3:0]         dir;
	} weather_rec_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         data_byte = 8'h00;
	logic               last_byte = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic signed [12:0] temperature_tenths;
	logic [7:0]         humidity_pct;
	logic [13:0]        avg_wind_hundredths;
	logic [13:0]        gust_wind_hundredths;
	logic [13:0]        rain_tenths;
	logic [3:0]         battery_bits;
	logic [3:0]         wind_dir_code;

	weather_frame_decoder_top dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_valid             (in_valid),
		.in_stall             (in_stall),
		.data_byte            (data_byte),
		.last_byte            (last_byte),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.status               (status),
		.temperature_tenths   (temperature_tenths),
		.humidity_pct         (humidity_pct),
		.avg_wind_hundredths  (avg_wind_hundredths),
		.gust_wind_hundredths (gust_wind_hundredths),
		.rain_tenths          (rain_tenths),
		.battery_bits         (battery_bits),
		.wind_dir_code        (wind_dir_code)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	burst_byte_t  pending_bytes[$];
	weather_rec_t frame_reports_q[$];
	byte_t        burst_buf [0:BUF_LEN-1];
	int unsigned  fail_count = 0;
	int unsigned  cycle_count = 0;
	int           in_gap = 0;
	int           in_quiet = 0;
	int           out_hold = 0;
	int           out_quiet = 0;
	burst_byte_t  next_item;

	// decoder model state
	int    frame_pos = 0;
	byte_t crc_run = 8'h00;
	logic  hdr_ok = 1'b0;
	byte_t fld_hold [0:7];

	function automatic byte_t crc31_update(input byte_t acc, input byte_t b);
		byte_t c;
		c = acc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ GEN_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	function automatic int gap_len(inout int quiet);
		int r;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			quiet = $urandom_range(20, 100);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic byte_t pick_content();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hff;
		return byte_t'($urandom_range(0, 255));
	endfunction

	task automatic decode_byte(input byte_t b, input logic last);
		weather_rec_t rec;
		if (frame_pos == 0)
			hdr_ok = (b == SYNC_BYTE);
		if (frame_pos >= 1 && frame_pos <= 9)
			crc_run = crc31_update(crc_run, b);
		if (frame_pos >= 2 && frame_pos <= 9)
			fld_hold[frame_pos-2] = b;
		if (!last) begin
			frame_pos = (frame_pos + 1 > POS_CAP) ? POS_CAP : frame_pos + 1;
		end else begin
			rec = '0;
			if (frame_pos + 1 != FRAME_LEN)
				rec.status = ST_BAD_LEN;
			else if (!hdr_ok)
				rec.status = ST_BAD_HDR;
			else if (crc_run != b)
				rec.status = ST_BAD_CRC;
			else
				rec.status = ST_OK;
			if (rec.status == ST_OK) begin
				rec.temp = $signed({1'b0, fld_hold[0][3:0], fld_hold[1]}) - 13'sd400;
				rec.hum  = fld_hold[2];
				rec.avg  = {6'd0, fld_hold[3]} * 14'd34;
				rec.gust = {6'd0, fld_hold[4]} * 14'd34;
				rec.rain = {2'd0, fld_hold[5][3:0], fld_hold[6]} * 14'd3;
				rec.batt = fld_hold[7][7:4];
				rec.dir  = fld_hold[7][3:0];
			end
			frame_reports_q.push_back(rec);
			frame_pos = 0;
			crc_run = 8'h00;
			hdr_ok = 1'b0;
		end
	endtask

	task automatic add_burst(input int n);
		burst_byte_t it;
		for (int i = 0; i < n; i++) begin
			it.data = burst_buf[i];
			it.last = (i == n - 1);
			pending_bytes.push_back(it);
		end
	endtask

	task automatic fill_good_frame();
		byte_t c;
		c = 8'h00;
		burst_buf[0] = SYNC_BYTE;
		for (int i = 1; i <= 9; i++) begin
			burst_buf[i] = pick_content();
			c = crc31_update(c, burst_buf[i]);
		end
		burst_buf[10] = c;
		for (int i = FRAME_LEN; i < BUF_LEN; i++)
			burst_buf[i] = pick_content();
	endtask

	task automatic fill_const_frame(input byte_t hdr, input byte_t v, input int n);
		byte_t c;
		c = 8'h00;
		burst_buf[0] = hdr;
		for (int i = 1; i <= 9; i++) begin
			burst_buf[i] = v;
			c = crc31_update(c, v);
		end
		burst_buf[10] = c;
		for (int i = FRAME_LEN; i < BUF_LEN; i++)
			burst_buf[i] = 8'h55;
		add_burst(n);
	endtask

	task automatic build_stimulus();
		burst_kind_t kind;
		int r;
		// largest fields, smallest fields, long burst with bad header, single byte
		fill_const_frame(SYNC_BYTE, 8'hff, FRAME_LEN);
		fill_const_frame(SYNC_BYTE, 8'h00, FRAME_LEN);
		fill_const_frame(8'h00, 8'h00, FRAME_LEN + 1);
		burst_buf[0] = 8'h00;
		add_burst(1);
		while (pending_bytes.size() < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				kind = GOOD_FRAME;
			else if (r < 67)
				kind = CRC_FLIP;
			else if (r < 79)
				kind = HDR_BAD;
			else if (r < 91)
				kind = LEN_BAD;
			else
				kind = NOISE;
			fill_good_frame();
			case (kind)
				GOOD_FRAME: begin
					add_burst(FRAME_LEN);
				end
				CRC_FLIP: begin
					burst_buf[10] = burst_buf[10] ^ (8'h01 << $urandom_range(0, 7));
					add_burst(FRAME_LEN);
				end
				HDR_BAD: begin
					burst_buf[0] = byte_t'($urandom_range(0, 254));
					if ($urandom_range(0, 1))
						burst_buf[10] = ~burst_buf[10];
					add_burst(FRAME_LEN);
				end
				LEN_BAD: begin
					if ($urandom_range(0, 1))
						add_burst($urandom_range(1, FRAME_LEN - 1));
					else
						add_burst($urandom_range(FRAME_LEN + 1, BUF_LEN));
				end
				default: begin
					for (int i = 0; i < BUF_LEN; i++)
						burst_buf[i] = byte_t'($urandom_range(0, 255));
					add_burst($urandom_range(1, 16));
				end
			endcase
		end
	endtask

	task automatic check_report();
		weather_rec_t got;
		weather_rec_t want;
		got.status = status;
		got.temp   = temperature_tenths;
		got.hum    = humidity_pct;
		got.avg    = avg_wind_hundredths;
		got.gust   = gust_wind_hundredths;
		got.rain   = rain_tenths;
		got.batt   = battery_bits;
		got.dir    = wind_dir_code;
		if (frame_reports_q.size() == 0) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("unexpected report: status %0d temp %0d", got.status, got.temp);
		end else begin
			want = frame_reports_q.pop_front();
			if (got !== want) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS) begin
					$display("mismatch exp/act: st %0d/%0d temp %0d/%0d hum %0d/%0d avg %0d/%0d",
						want.status, got.status, want.temp, got.temp, want.hum, got.hum,
						want.avg, got.avg);
					$display("  gust %0d/%0d rain %0d/%0d batt %0d/%0d dir %0d/%0d",
						want.gust, got.gust, want.rain, got.rain,
						want.batt, got.batt, want.dir, got.dir);
				end
			end
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				decode_byte(data_byte, last_byte);
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap = in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					next_item = pending_bytes.pop_front();
					in_valid  <= 1'b1;
					data_byte <= next_item.data;
					last_byte <= next_item.last;
					in_gap = gap_len(in_quiet);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				check_report();
			if (out_hold > 0) begin
				out_hold = out_hold - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				out_hold = gap_len(out_quiet);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[weather_frame_decoder_top] ERROR");
			$finish;
		end
	end

	initial begin
		build_stimulus();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		do
			@(negedge clk);
		while (pending_bytes.size() != 0 || in_valid || frame_reports_q.size() != 0);
		repeat (DRAIN_CYC) @(posedge clk);
		if (frame_reports_q.size() != 0) begin
			fail_count += frame_reports_q.size();
			$display("%0d frame reports never arrived", frame_reports_q.size());
		end
		if (fail_count == 0)
			$display("[weather_frame_decoder_top] OK");
		else
			$display("[weather_frame_decoder_top] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/wfd_pkg.sv
hdl/wfd_front.sv
hdl/wfd_fifo.sv
hdl/wfd_back.sv
hdl/weather_frame_decoder_top.sv
dv/testbench.sv
